/* hdl/adsw_pkg.sv */
`timescale 1ns / 1ps
// Package for the angular density evaluator: payload and configuration types,
// fixed-point constants, the arctangent table and the shared rounding multiply.
// No dependencies.
package adsw_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int TRIG_STAGES = 16;
  localparam int SQRT_STEPS  = 15;
  localparam int NUM_REGS    = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int Z_W         = 35;
  localparam int XY_W        = 34;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_FRACTION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_S7_COEFF       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AT2_COEFF      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWAVE_FRACTION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AS_COEFF       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A7S_COEFF      = 3'd5;

  localparam logic signed [Z_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [XY_W-1:0] GAIN_Q30   = 34'sd652032874;

  localparam logic signed [23:0] DENS_MAX = 24'sd131071;
  localparam logic signed [23:0] DENS_MIN = -24'sd131072;

  typedef logic signed [23:0] val_t;

  typedef struct packed {
    logic signed [15:0] cos_lepton;
    logic signed [15:0] cos_kaon;
    logic [15:0]        azimuth;
  } item_t;

  typedef struct packed {
    logic signed [17:0] density;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [15:0] long_fraction;
    logic signed [15:0] s7_coeff;
    logic signed [15:0] at2_coeff;
    logic signed [15:0] swave_fraction;
    logic signed [15:0] as_coeff;
    logic signed [15:0] a7s_coeff;
  } cfg_t;

  function automatic logic signed [15:0] clamp_q(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > 16'sd16384) r = 16'sd16384;
    else if (v < -16'sd16384) r = -16'sd16384;
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_frac(input logic [14:0] v);
    logic signed [15:0] r;
    r = (v > 15'd16384) ? 16'sd16384 : $signed({1'b0, v});
    return r;
  endfunction

  // round to nearest, ties up, at FRAC_BITS
  function automatic val_t fmul(input val_t a, input val_t b);
    logic signed [47:0] p;
    p = 48'(a) * 48'(b) + 48'sd8192;
    return p[37:14];
  endfunction

  function automatic val_t from_q30(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    logic signed [17:0]     s;
    val_t                   r;
    t = v + 34'sd32768;
    s = t[XY_W-1:16];
    r = val_t'(s);
    if (s > 18'sd16384) r = 24'sd16384;
    else if (s < -18'sd16384) r = -24'sd16384;
    return r;
  endfunction

  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0: r = 35'sh3243F6A8;  1: r = 35'sh1DAC6705;  2: r = 35'sh0FADBAFC;
      3: r = 35'sh07F56EA6;  4: r = 35'sh03FEAB76;  5: r = 35'sh01FFD55B;
      6: r = 35'sh00FFFAAA;  7: r = 35'sh007FFF55;  8: r = 35'sh003FFFEA;
      9: r = 35'sh001FFFFD;  10: r = 35'sh000FFFFF; 11: r = 35'sh0007FFFF;
      12: r = 35'sh0003FFFF; 13: r = 35'sh0001FFFF; 14: r = 35'sh0000FFFF;
      15: r = 35'sh00007FFF; 16: r = 35'sh00003FFF; 17: r = 35'sh00001FFF;
      18: r = 35'sh00000FFF; 19: r = 35'sh000007FF; 20: r = 35'sh000003FF;
      21: r = 35'sh000001FF; 22: r = 35'sh000000FF; 23: r = 35'sh0000007F;
      24: r = 35'sh0000003F; 25: r = 35'sh0000001F; 26: r = 35'sh0000000F;
      27: r = 35'sh00000008; 28: r = 35'sh00000004; 29: r = 35'sh00000002;
      30: r = 35'sh00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/adsw_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined integer square root giving sin = sqrt(ONE^2 - c^2), one result bit
// per stage, SQRT_STEPS bits; the clamped cosine rides along. Depends on adsw_pkg.
module adsw_sqrt #(
  parameter int STAGES = 16
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [15:0]   cos_in,
  output logic signed [15:0]   cos_out,
  output logic signed [15:0]   sin_out
);
  import adsw_pkg::*;

  logic [28:0]        n [0:STAGES];
  logic [29:0]        r [0:STAGES];
  logic signed [15:0] c [0:STAGES];
  logic signed [15:0] cin;
  logic signed [31:0] sq;

  assign cin = clamp_q(cos_in);
  assign sq  = cin * cin;

  always_ff @(posedge clk) begin
    if (adv) begin
      n[0] <= 29'(32'sd268435456 - sq);
      r[0] <= '0;
      c[0] <= cin;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_step
    localparam logic [30:0] BIT = (i < SQRT_STEPS) ? (31'd1 << (28 - 2 * i)) : 31'd0;
    logic [30:0] trial;
    logic [28:0] n_next;
    logic [29:0] r_next;
    always_comb begin
      trial  = 31'(r[i]) + BIT;
      n_next = n[i];
      r_next = r[i];
      if (i < SQRT_STEPS) begin
        if (31'(n[i]) >= trial) begin
          n_next = 29'(31'(n[i]) - trial);
          r_next = 30'((31'(r[i]) >> 1) + BIT);
        end else begin
          r_next = r[i] >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        n[i+1] <= n_next;
        r[i+1] <= r_next;
        c[i+1] <= c[i];
      end
    end
  end

  assign cos_out = c[STAGES];
  assign sin_out = $signed({1'b0, r[STAGES][14:0]});

endmodule

/* hdl/adsw_cordic.sv */
`timescale 1ns / 1ps
// Pipelined CORDIC rotation for sin(phi) and cos(phi) in Q30, with range
// reduction in the entry stage; carries the request valid bit. Depends on adsw_pkg.
module adsw_cordic #(
  parameter int STAGES = 16,
  parameter int TRIG   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [15:0]                 azimuth,
  output logic                        out_valid,
  output logic signed [adsw_pkg::XY_W-1:0] out_x,
  output logic signed [adsw_pkg::XY_W-1:0] out_y,
  output logic                        out_neg
);
  import adsw_pkg::*;

  logic signed [XY_W-1:0] x [0:STAGES];
  logic signed [XY_W-1:0] y [0:STAGES];
  logic signed [Z_W-1:0]  z [0:STAGES];
  logic                   ng [0:STAGES];
  logic                   v [0:STAGES];

  logic signed [Z_W-1:0] z0, z1, z_next;
  logic                  neg_next;

  always_comb begin
    z0 = $signed({3'b0, azimuth, 16'b0});
    z1 = (z0 > PI_Q30) ? z0 - TWO_PI_Q30 : z0;
    z_next   = z1;
    neg_next = 1'b0;
    if (z1 > HALF_PI_Q30) begin
      z_next   = PI_Q30 - z1;
      neg_next = 1'b1;
    end else if (z1 < -HALF_PI_Q30) begin
      z_next   = -PI_Q30 - z1;
      neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x[0]  <= GAIN_Q30;
      y[0]  <= '0;
      z[0]  <= z_next;
      ng[0] <= neg_next;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [Z_W-1:0] ANG = atan_q30(i);
    logic signed [XY_W-1:0] x_next, y_next;
    logic signed [Z_W-1:0]  zz_next;
    always_comb begin
      x_next  = x[i];
      y_next  = y[i];
      zz_next = z[i];
      if (i < TRIG) begin
        if (z[i] >= 0) begin
          x_next  = x[i] - (y[i] >>> i);
          y_next  = y[i] + (x[i] >>> i);
          zz_next = z[i] - ANG;
        end else begin
          x_next  = x[i] + (y[i] >>> i);
          y_next  = y[i] - (x[i] >>> i);
          zz_next = z[i] + ANG;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        x[i+1]  <= x_next;
        y[i+1]  <= y_next;
        z[i+1]  <= zz_next;
        ng[i+1] <= ng[i];
      end
    end
  end

  assign out_valid = v[STAGES];
  assign out_x     = x[STAGES];
  assign out_y     = y[STAGES];
  assign out_neg   = ng[STAGES];

endmodule

/* hdl/adsw_terms.sv */
`timescale 1ns / 1ps
// Density arithmetic: eight register stages of rounding multiplies, the P-wave
// and S-wave sums and the final saturation. Depends on adsw_pkg.
module adsw_terms (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  adsw_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  input  logic signed [15:0]          cl_in,
  input  logic signed [15:0]          ck_in,
  input  logic signed [15:0]          sl_in,
  input  logic signed [15:0]          sk_in,
  input  logic signed [adsw_pkg::XY_W-1:0] x_in,
  input  logic signed [adsw_pkg::XY_W-1:0] y_in,
  input  logic                        neg_in,
  output logic                        out_valid,
  output adsw_pkg::result_t           out_data
);
  import adsw_pkg::*;

  val_t one_v, fl, s7, at2, fs, as_c, a7s;
  assign one_v = val_t'(ONE);
  assign fl    = val_t'(cfg.long_fraction);
  assign s7    = val_t'(cfg.s7_coeff);
  assign at2   = val_t'(cfg.at2_coeff);
  assign fs    = val_t'(cfg.swave_fraction);
  assign as_c  = val_t'(cfg.as_coeff);
  assign a7s   = val_t'(cfg.a7s_coeff);

  logic [7:1] v;

  // stage 1
  val_t s1_ck, s1_sl, s1_sphi, s1_cphi, s1_cl2, s1_ck2, s1_skck, s1_a7sk;
  // stage 2
  val_t s2_ck, s2_sl, s2_sphi, s2_sl2, s2_cos2l, s2_a, s2_b, s2_cc, s2_ss;
  val_t s2_g1, s2_fssl2, s2_assl2, s2_a7;
  // stage 3
  val_t s3_sl, s3_sphi, s3_sl2, s3_a, s3_b, s3_cos2phi, s3_c, s3_d, s3_e1;
  val_t s3_g2, s3_fssl2, s3_asck, s3_a7;
  // stage 4
  val_t s4_a, s4_b, s4_c, s4_d, s4_cos2phi, s4_e2, s4_g, s4_sw;
  // stage 5
  val_t s5_a, s5_b, s5_c, s5_d, s5_e, s5_g, s5_sw;
  // stage 6
  val_t s6_acc, s6_sw;
  // stage 7
  val_t s7_p, s7_sw;

  val_t total, dens;

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v         <= {v[6:1], in_valid};
      out_valid <= v[7];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ck   <= val_t'(ck_in);
      s1_sl   <= val_t'(sl_in);
      s1_sphi <= from_q30(y_in);
      s1_cphi <= from_q30(neg_in ? -x_in : x_in);
      s1_cl2  <= fmul(val_t'(cl_in), val_t'(cl_in));
      s1_ck2  <= fmul(val_t'(ck_in), val_t'(ck_in));
      s1_skck <= fmul(val_t'(sk_in), val_t'(ck_in));
      s1_a7sk <= fmul(a7s, val_t'(sk_in));

      s2_ck    <= s1_ck;
      s2_sl    <= s1_sl;
      s2_sphi  <= s1_sphi;
      s2_sl2   <= one_v - s1_cl2;
      s2_cos2l <= (s1_cl2 <<< 1) - one_v;
      s2_a     <= fmul(one_v - fl, one_v - s1_ck2);
      s2_b     <= fmul(fl, s1_ck2);
      s2_cc    <= fmul(s1_cphi, s1_cphi);
      s2_ss    <= fmul(s1_sphi, s1_sphi);
      s2_g1    <= fmul(s7, s1_skck <<< 1);
      s2_fssl2 <= fmul(fs, one_v - s1_cl2);
      s2_assl2 <= fmul(as_c, one_v - s1_cl2);
      s2_a7    <= fmul(s1_a7sk, s1_sl);

      s3_sl      <= s2_sl;
      s3_sphi    <= s2_sphi;
      s3_sl2     <= s2_sl2;
      s3_a       <= s2_a;
      s3_b       <= s2_b;
      s3_cos2phi <= s2_cc - s2_ss;
      s3_c       <= fmul(s2_a, s2_cos2l);
      s3_d       <= fmul(s2_b, s2_cos2l);
      s3_e1      <= fmul(s2_a, at2);
      s3_g2      <= fmul(s2_g1, s2_sl);
      s3_fssl2   <= s2_fssl2;
      s3_asck    <= fmul(s2_assl2, s2_ck);
      s3_a7      <= fmul(s2_a7, s2_sphi);

      s4_a       <= s3_a;
      s4_b       <= s3_b;
      s4_c       <= s3_c;
      s4_d       <= s3_d;
      s4_cos2phi <= s3_cos2phi;
      s4_e2      <= fmul(s3_e1, s3_sl2);
      s4_g       <= fmul(s3_g2, s3_sphi);
      s4_sw      <= s3_fssl2 + s3_asck + s3_a7;

      s5_a  <= s4_a;
      s5_b  <= s4_b;
      s5_c  <= s4_c;
      s5_d  <= s4_d;
      s5_e  <= fmul(s4_e2, s4_cos2phi);
      s5_g  <= s4_g;
      s5_sw <= s4_sw;

      // P-wave sum at four times scale
      s6_acc <= (s5_a <<< 1) + s5_a + (s5_b <<< 2) + s5_c - (s5_d <<< 2)
              + (s5_e <<< 1) + (s5_g <<< 2);
      s6_sw  <= s5_sw;

      s7_p  <= fmul(s6_acc, one_v - fs);
      s7_sw <= s6_sw;
    end
  end

  always_comb begin
    total = s7_p + (s7_sw <<< 2) + 24'sd2;
    dens  = total >>> 2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dens > DENS_MAX) begin
        out_data.density   <= DENS_MAX[17:0];
        out_data.saturated <= 1'b1;
      end else if (dens < DENS_MIN) begin
        out_data.density   <= DENS_MIN[17:0];
        out_data.saturated <= 1'b1;
      end else begin
        out_data.density   <= dens[17:0];
        out_data.saturated <= 1'b0;
      end
    end
  end

  // the truncation on s6_acc would be a silent bug if the sum overflowed
  // into the sign; the output field can never hold a value outside the clip
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.density == DENS_MAX[17:0]) || (out_data.density == DENS_MIN[17:0]))
    else $error("saturated flag without clipped density");

  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(out_data) && $stable(v))
    else $error("pipeline moved while held");

endmodule

/* hdl/angular_density_s7_swave.sv */
`timescale 1ns / 1ps
// Angular density evaluator, top level. Throughput: one request per cycle;
// the whole pipeline holds while a result is stalled. Synchronous reset
// clears valid bits and all coefficients to 0.
module angular_density_s7_swave #(
  parameter int TRIG_STAGES = adsw_pkg::TRIG_STAGES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  adsw_pkg::item_t                    item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output adsw_pkg::result_t                  result,
  input  logic                               cfg_we,
  input  logic [adsw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adsw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import adsw_pkg::*;

  localparam int FRONT = (TRIG_STAGES > SQRT_STEPS) ? TRIG_STAGES : SQRT_STEPS;

  cfg_t cfg;
  logic adv;
  logic f_valid, f_neg;
  logic signed [XY_W-1:0] f_x, f_y;
  logic signed [15:0] cl, ck, sl, sk;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_FRACTION:  cfg.long_fraction  <= clamp_frac(cfg_data[14:0]);
        REG_S7_COEFF:       cfg.s7_coeff       <= clamp_q($signed(cfg_data));
        REG_AT2_COEFF:      cfg.at2_coeff      <= clamp_frac(cfg_data[14:0]);
        REG_SWAVE_FRACTION: cfg.swave_fraction <= clamp_frac(cfg_data[14:0]);
        REG_AS_COEFF:       cfg.as_coeff       <= clamp_q($signed(cfg_data));
        REG_A7S_COEFF:      cfg.a7s_coeff      <= clamp_q($signed(cfg_data));
        default: ;
      endcase
    end
  end

  adsw_sqrt #(.STAGES(FRONT)) u_sqrt_l (
    .clk(clk), .adv(adv), .cos_in(item.cos_lepton), .cos_out(cl), .sin_out(sl)
  );

  adsw_sqrt #(.STAGES(FRONT)) u_sqrt_k (
    .clk(clk), .adv(adv), .cos_in(item.cos_kaon), .cos_out(ck), .sin_out(sk)
  );

  adsw_cordic #(.STAGES(FRONT), .TRIG(TRIG_STAGES)) u_cordic (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(item_valid && !item_stall),
    .azimuth(item.azimuth), .out_valid(f_valid), .out_x(f_x), .out_y(f_y),
    .out_neg(f_neg)
  );

  adsw_terms u_terms (
    .clk(clk), .rst(rst), .adv(adv), .cfg(cfg), .in_valid(f_valid),
    .cl_in(cl), .ck_in(ck), .sl_in(sl), .sk_in(sk), .x_in(f_x), .y_in(f_y),
    .neg_in(f_neg), .out_valid(result_valid), .out_data(result)
  );

  assert property (@(posedge clk) !rst && $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index > REG_A7S_COEFF) |=> $stable(cfg))
    else $error("write beyond register list changed configuration");

  assert property (@(posedge clk) disable iff (rst)
    !cfg_we |=> $stable(cfg))
    else $error("configuration changed without a write");

endmodule

/* tb/tb_angular_density_s7_swave.sv */
`timescale 1ns / 1ps
// Self-checking bench for angular_density_s7_swave: a stimulus table and then
// random events under several coefficient settings, scored against a local model.
// Depends on adsw_pkg and the angular_density_s7_swave RTL.
module tb_angular_density_s7_swave;
  import adsw_pkg::*;

  localparam int NDIR = 15;
  localparam int NPHASE = 9;
  localparam int PHASE_ITEMS = 178;
  localparam int DRAIN = 40;
  localparam longint QONE = 64'sd16384;
  localparam longint Q30_PI = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_TWO_PI = 64'sd6746518852;
  localparam longint Q30_GAIN = 64'sd652032874;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [15:0] coef [NUM_REGS];
  result_t density_q[$];
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int tx_idle = 0;
  int rx_idle = 0;

  longint atan_tab [16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF};

  logic [15:0] dir_cl [NDIR] = '{16'h0000, 16'h4000, 16'h0000, 16'h4000, 16'hC000,
    16'h7FFF, 16'h8000, 16'h2000, 16'hE000, 16'h0001, 16'h3FFF, 16'h0000,
    16'h4001, 16'h1234, 16'hFFFF};
  logic [15:0] dir_ck [NDIR] = '{16'h4000, 16'hC000, 16'h0000, 16'h4000, 16'h0000,
    16'h8000, 16'h7FFF, 16'hE000, 16'h2000, 16'hFFFF, 16'hC001, 16'h0000,
    16'hBFFF, 16'h5678, 16'h0001};
  logic [15:0] dir_az [NDIR] = '{16'd0, 16'd51472, 16'd0, 16'd0, 16'd25736,
    16'd65535, 16'd51472, 16'd12868, 16'd38604, 16'd1, 16'd51471, 16'd32768,
    16'hFFFF, 16'hABCD, 16'h8000};
  // kaon at the pole with all coefficients zero gives exactly zero
  logic dir_zero [NDIR] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  angular_density_s7_swave uut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_stall(item_stall),
    .item(item), .result_valid(result_valid), .result_stall(result_stall),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (QONE >>> 1)) >>> 14;
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint q30_to_q14(longint v);
    return clip((v + 64'sd32768) >>> 16, -QONE, QONE);
  endfunction

  task automatic phi_trig(input logic [15:0] az, output longint sn, output longint cs);
    longint z, x, y, nx;
    bit flip;
    z = longint'((longint'(az) << 16) % Q30_TWO_PI);
    x = Q30_GAIN;
    y = 0;
    flip = 0;
    if (z > Q30_PI) z = z - Q30_TWO_PI;
    if (z > Q30_HALF_PI) begin
      z = Q30_PI - z;
      flip = 1;
    end else if (z < -Q30_HALF_PI) begin
      z = -Q30_PI - z;
      flip = 1;
    end
    for (int i = 0; i < TRIG_STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_tab[i];
      end
      x = nx;
    end
    sn = q30_to_q14(y);
    cs = q30_to_q14(flip ? -x : x);
  endtask

  task automatic density_of(input item_t it, output result_t r);
    longint fl, s7, at2, fs, as_c, a7s, cl, ck, sl, sk, cl2, ck2, sl2, sk2, c2l;
    longint sphi, cphi, c2phi, a, b, c, d, e, g, acc, dens;
    fl = clip(longint'(coef[REG_LONG_FRACTION][14:0]), 0, QONE);
    s7 = clip(longint'($signed(coef[REG_S7_COEFF])), -QONE, QONE);
    at2 = clip(longint'(coef[REG_AT2_COEFF][14:0]), 0, QONE);
    fs = clip(longint'(coef[REG_SWAVE_FRACTION][14:0]), 0, QONE);
    as_c = clip(longint'($signed(coef[REG_AS_COEFF])), -QONE, QONE);
    a7s = clip(longint'($signed(coef[REG_A7S_COEFF])), -QONE, QONE);
    cl = clip(longint'(it.cos_lepton), -QONE, QONE);
    ck = clip(longint'(it.cos_kaon), -QONE, QONE);
    sl = root_floor(longint'(QONE * QONE - cl * cl));
    sk = root_floor(longint'(QONE * QONE - ck * ck));
    cl2 = qmul(cl, cl);
    ck2 = qmul(ck, ck);
    sl2 = QONE - cl2;
    sk2 = QONE - ck2;
    c2l = 2 * cl2 - QONE;
    phi_trig(it.azimuth, sphi, cphi);
    c2phi = qmul(cphi, cphi) - qmul(sphi, sphi);
    a = qmul(QONE - fl, sk2);
    b = qmul(fl, ck2);
    c = qmul(a, c2l);
    d = qmul(b, c2l);
    e = qmul(qmul(qmul(a, at2), sl2), c2phi);
    g = qmul(qmul(qmul(s7, 2 * qmul(sk, ck)), sl), sphi);
    acc = qmul(3 * a + 4 * b + c - 4 * d + 2 * e + 4 * g, QONE - fs);
    acc = acc + 4 * (qmul(fs, sl2) + qmul(qmul(as_c, sl2), ck)
                     + qmul(qmul(qmul(a7s, sk), sl), sphi));
    dens = (acc + 2) >>> 2;
    r.saturated = 1'b0;
    if (dens > 131071) begin
      dens = 131071;
      r.saturated = 1'b1;
    end else if (dens < -131072) begin
      dens = -131072;
      r.saturated = 1'b1;
    end
    r.density = dens[17:0];
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s at result %0d: got %0d want %0d", what, n_results, got, want);
  endtask

  always @(negedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < rx_idle);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (density_q.size() == 0) begin
        report("unexpected result", result.density, 0);
      end else begin
        want = density_q.pop_front();
        if (result.density !== want.density)
          report("density", result.density, want.density);
        if (result.saturated !== want.saturated)
          report("saturated", result.saturated, want.saturated);
      end
      n_results++;
    end
  end

  task automatic write_reg(input int idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx[CFG_IDX_W-1:0];
    cfg_data = val;
    if (idx < NUM_REGS) coef[idx] = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain;
    while (density_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  // caller sits at a falling edge; returns at the falling edge after acceptance
  task automatic send(input item_t it, input bit zero_known);
    result_t r;
    while ($urandom_range(99) < tx_idle) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item = it;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    if (zero_known) r = '0;
    else density_of(it, r);
    density_q.push_back(r);
    n_requests++;
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  task automatic run_table(input bit fresh);
    item_t it;
    for (int i = 0; i < NDIR; i++) begin
      it.cos_lepton = dir_cl[i];
      it.cos_kaon = dir_ck[i];
      it.azimuth = dir_az[i];
      send(it, fresh && dir_zero[i]);
    end
  endtask

  function automatic logic [15:0] rand_signed_coef();
    return $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(32768) - 16384);
  endfunction

  function automatic logic [15:0] rand_frac_coef();
    return $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(16384));
  endfunction

  initial begin
    item_t it;
    for (int i = 0; i < NUM_REGS; i++) coef[i] = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    tx_idle = 34;
    rx_idle = 69;
    run_table(1'b1);
    drain();
    for (int p = 0; p < NPHASE; p++) begin
      if (p == 3) begin
        tx_idle = 69;
        rx_idle = 34;
      end else if (p == 6) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      for (int r = 0; r < NUM_REGS; r++) begin
        case (p)
          0: write_reg(r, 16'd16384);
          1: write_reg(r, (r == REG_S7_COEFF || r == REG_AS_COEFF || r == REG_A7S_COEFF)
                          ? 16'hC000 : 16'd0);
          2: write_reg(r, (r % 2) ? 16'h8000 : 16'h7FFF);
          3: write_reg(r, 16'hFFFF);
          default: write_reg(r, (r == REG_S7_COEFF || r == REG_AS_COEFF ||
                                 r == REG_A7S_COEFF) ? rand_signed_coef() : rand_frac_coef());
        endcase
      end
      write_reg(6, 16'($urandom));
      write_reg(7, 16'($urandom));
      if (p < 3) run_table(1'b0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(4) == 0) begin
          it = item_t'({$urandom, 16'($urandom)});
        end else begin
          it.cos_lepton = 16'($urandom_range(32768) - 16384);
          it.cos_kaon = 16'($urandom_range(32768) - 16384);
          it.azimuth = 16'($urandom_range(51472));
        end
        send(it, 1'b0);
        if (p == 4 && k == PHASE_ITEMS / 2) drain();
      end
      drain();
    end
    $display("covered %0d requests and %0d results over %0d coefficient settings",
             n_requests, n_results, NPHASE + 1);
    if (errors == 0) begin
      $display("angular_density_s7_swave regression: pass");
    end else begin
      $display("angular_density_s7_swave regression: fail");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("angular_density_s7_swave regression: fail");
    $finish;
  end

endmodule
